/* hw/rtl/rcrc_pkg.sv */
// shared constants and types for the reflected crc escaped stream unit
package rcrc_pkg;

    // field and register widths
    localparam int CHAR_W      = 8;
    localparam int NIBBLE_W    = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;
    localparam int CRC_OUT_W   = 32;
    localparam int WIDTH_REG_W = 6;
    localparam int PHASE_W     = 2;

    typedef logic [PHASE_W-1:0] phase_t;

    // escape phase codes
    localparam phase_t PH_NORMAL = 2'd0;
    localparam phase_t PH_HIGH   = 2'd1;
    localparam phase_t PH_LOW    = 2'd2;

    // escape opener
    localparam logic [CHAR_W-1:0] ESC_CHAR = 8'h25;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLYNOMIAL = 1'd1;

    // configuration reset values
    localparam logic [WIDTH_REG_W-1:0] RESET_CRC_WIDTH  = 6'd32;
    localparam logic [CFG_DATA_W-1:0]  RESET_POLYNOMIAL = 32'h04C11DB7;

endpackage

/* hw/rtl/rcrc_byte_step.sv */
// eight-bit reflected-input crc update over a variable register width
module rcrc_byte_step
    import rcrc_pkg::*;
#(
    parameter int MAX_CRC_WIDTH = 32
)
(
    input  logic [MAX_CRC_WIDTH-1:0] crc_in,
    input  logic [CHAR_W-1:0]        data,
    input  logic [WIDTH_REG_W-1:0]   width,
    input  logic [MAX_CRC_WIDTH-1:0] mask,
    input  logic [MAX_CRC_WIDTH-1:0] poly,
    output logic [MAX_CRC_WIDTH-1:0] crc_out
);

    localparam int IDX_W = $clog2(MAX_CRC_WIDTH);

    logic [IDX_W-1:0] top_idx;

    assign top_idx = IDX_W'(width - WIDTH_REG_W'(1));

    // shift the byte in lsb first, feedback from the top used bit
    always_comb
    begin
        logic [MAX_CRC_WIDTH-1:0] r;
        logic                     fb;
        r = crc_in;
        for (int j = 0; j < CHAR_W; j++)
        begin
            fb = r[top_idx] ^ data[j];
            r  = (r << 1) & mask;
            if (fb)
            begin
                r = r ^ poly;
            end
        end
        crc_out = r;
    end

endmodule

/* hw/rtl/rcrc_reflect.sv */
// bit reversal of the crc over its used width, zero above
module rcrc_reflect
    import rcrc_pkg::*;
#(
    parameter int MAX_CRC_WIDTH = 32
)
(
    input  logic [MAX_CRC_WIDTH-1:0] value,
    input  logic [WIDTH_REG_W-1:0]   width,
    input  logic [MAX_CRC_WIDTH-1:0] mask,
    output logic [MAX_CRC_WIDTH-1:0] reflected
);

    logic [MAX_CRC_WIDTH-1:0] masked;
    logic [MAX_CRC_WIDTH-1:0] reversed;
    logic [WIDTH_REG_W-1:0]   shift;

    assign masked = value & mask;
    assign shift  = WIDTH_REG_W'(MAX_CRC_WIDTH) - width;

    // full-width reversal, then drop the unused low positions
    always_comb
    begin
        for (int i = 0; i < MAX_CRC_WIDTH; i++)
        begin
            reversed[i] = masked[MAX_CRC_WIDTH-1-i];
        end
    end

    assign reflected = reversed >> shift;

endmodule

/* hw/rtl/reflected_crc_escaped_stream_unit.sv */
// top level of the reflected crc escaped stream unit
//
// Takes one character per request on the item channel (char_in, is_final)
// and decodes percent escapes: a '%' and the two characters after it form
// one byte from their low nibbles. Each data byte updates a reflected-input
// crc, initial value zero, of crc_width bits with the programmed polynomial.
// On the final character one request leaves on the result channel: the
// bit-reflected crc and a status, 1 when the message ends inside an escape
// (crc_value is then zero). The message state then clears.
// Throughput is one character per cycle while item_stall is low; the byte update is eight unrolled
// shift steps between the input register and the result register.
// The result is registered: a final character passes the input register, then the result register.
// The result channel holds its request while result_stall is high; a final
// character waiting behind a stalled result raises item_stall, other
// characters keep flowing.
// The configuration port (cfg_index, cfg_data) is always ready; the user must write it only while
// no message is in flight, as the block itself does not enforce this.
// Reset clears the message state and loads width 32, polynomial 0x04C11DB7.
module reflected_crc_escaped_stream_unit
    import rcrc_pkg::*;
#(
    parameter int MAX_CRC_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic [CHAR_W-1:0]     char_in,
    input  logic                  is_final,

    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [CRC_OUT_W-1:0]  crc_value,
    output logic                  status,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [WIDTH_REG_W-1:0] crc_width_reg;
    logic [CFG_DATA_W-1:0]  polynomial_reg;

    // input register
    logic                   in_valid_reg;
    logic [CHAR_W-1:0]      char_reg;
    logic                   final_reg;

    // message state
    logic [MAX_CRC_WIDTH-1:0] crc_reg;
    logic [MAX_CRC_WIDTH-1:0] crc_next;
    phase_t                   phase_reg;
    phase_t                   phase_next;
    logic [NIBBLE_W-1:0]      nibble_reg;
    logic [NIBBLE_W-1:0]      nibble_next;

    // result register
    logic                   result_valid_reg;
    logic [CRC_OUT_W-1:0]   crc_value_reg;
    logic                   status_reg;

    logic                     proceed;
    logic                     feed;
    logic                     truncated;
    logic [CHAR_W-1:0]        feed_byte;
    logic [WIDTH_REG_W-1:0]   eff_width;
    logic [MAX_CRC_WIDTH-1:0] mask;
    logic [MAX_CRC_WIDTH-1:0] poly;
    logic [MAX_CRC_WIDTH-1:0] crc_stepped;
    logic [MAX_CRC_WIDTH-1:0] crc_reflected;

    assign cfg_ready = 1'b1;

    // configuration write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_width_reg  <= RESET_CRC_WIDTH;
            polynomial_reg <= RESET_POLYNOMIAL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CRC_WIDTH:  crc_width_reg  <= cfg_data[WIDTH_REG_W-1:0];
                CFG_POLYNOMIAL: polynomial_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // clamp the width into 1..MAX_CRC_WIDTH
    always_comb
    begin
        if (crc_width_reg == '0)
        begin
            eff_width = WIDTH_REG_W'(1);
        end
        else if (crc_width_reg > WIDTH_REG_W'(MAX_CRC_WIDTH))
        begin
            eff_width = WIDTH_REG_W'(MAX_CRC_WIDTH);
        end
        else
        begin
            eff_width = crc_width_reg;
        end
    end

    // used-bit mask and masked generator
    always_comb
    begin
        for (int i = 0; i < MAX_CRC_WIDTH; i++)
        begin
            mask[i] = (WIDTH_REG_W'(i) < eff_width);
        end
    end

    assign poly = polynomial_reg[MAX_CRC_WIDTH-1:0] & mask;

    // a final item waits only for a free result slot
    assign proceed    = in_valid_reg && (!final_reg || !result_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !proceed;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_valid && !item_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proceed)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            char_reg  <= char_in;
            final_reg <= is_final;
        end
    end

    // escape decode
    always_comb
    begin
        phase_next  = PH_NORMAL;
        nibble_next = nibble_reg;
        feed        = 1'b0;
        truncated   = 1'b0;
        feed_byte   = char_reg;
        unique case (phase_reg)
            PH_HIGH:
            begin
                nibble_next = char_reg[NIBBLE_W-1:0];
                phase_next  = PH_LOW;
                truncated   = 1'b1;
            end
            PH_LOW:
            begin
                feed      = 1'b1;
                feed_byte = {nibble_reg, char_reg[NIBBLE_W-1:0]};
            end
            default:
            begin
                if (char_reg == ESC_CHAR)
                begin
                    phase_next = PH_HIGH;
                    truncated  = 1'b1;
                end
                else
                begin
                    feed = 1'b1;
                end
            end
        endcase
    end

    rcrc_byte_step #(
        .MAX_CRC_WIDTH (MAX_CRC_WIDTH)
    ) u_byte_step (
        .crc_in  (crc_reg),
        .data    (feed_byte),
        .width   (eff_width),
        .mask    (mask),
        .poly    (poly),
        .crc_out (crc_stepped)
    );

    rcrc_reflect #(
        .MAX_CRC_WIDTH (MAX_CRC_WIDTH)
    ) u_reflect (
        .value     (crc_stepped),
        .width     (eff_width),
        .mask      (mask),
        .reflected (crc_reflected)
    );

    assign crc_next = feed ? crc_stepped : crc_reg;

    // message state, cleared after the final character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg    <= '0;
            phase_reg  <= PH_NORMAL;
            nibble_reg <= '0;
        end
        else if (proceed)
        begin
            if (final_reg)
            begin
                crc_reg    <= '0;
                phase_reg  <= PH_NORMAL;
                nibble_reg <= '0;
            end
            else
            begin
                crc_reg    <= crc_next;
                phase_reg  <= phase_next;
                nibble_reg <= nibble_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (proceed && final_reg)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proceed && final_reg)
        begin
            crc_value_reg <= truncated ? '0 : CRC_OUT_W'(crc_reflected);
            status_reg    <= truncated;
        end
    end

    assign result_valid = result_valid_reg;
    assign crc_value    = crc_value_reg;
    assign status       = status_reg;

`ifndef SYNTHESIS
    // a truncated escape never carries a crc
    a_trunc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status) |-> (crc_value == '0))
        else $error("truncated result with nonzero crc");

    // the item side stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (final_reg && result_valid_reg && result_stall))
        else $error("item stall without a blocked final");

    // a processed final item yields a result request
    a_final_result: assert property (@(posedge clk) disable iff (!rst_n)
        (proceed && final_reg) |=> result_valid)
        else $error("final item without result");

    // message state is clear after a final item
    a_final_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (proceed && final_reg) |=> (phase_reg == PH_NORMAL && crc_reg == '0))
        else $error("state not cleared after final");
`endif

endmodule
